[src/lcgr_pkg.sv]
// Shared constants for the bounded linear congruential random generator.
package lcgr_pkg;

	// Field and datapath widths.
	localparam int BOUND_W = 16;
	localparam int SPAN_W  = BOUND_W + 1;
	localparam int SEED_W  = 31;
	localparam int CNT_W   = $clog2(SEED_W);

	// Generator constants.
	localparam logic [SEED_W-1:0] LCG_MULT   = SEED_W'(1103515245);
	localparam logic [SEED_W-1:0] LCG_INC    = SEED_W'(81800);
	localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(81800);

	// Starting value of the step counter of the serial multiply and the serial remainder.
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SEED_W - 1);

endpackage

[src/lcgr_rem.sv]
// Bit-serial remainder of the 31-bit seed by a 17-bit span, one bit per cycle.
module lcgr_rem
	import lcgr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SEED_W-1:0]    dividend,
	input  logic [SPAN_W-1:0]    divisor,
	output logic                 done,
	output logic [BOUND_W-1:0]   remainder
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SEED_W-1:0]   dvd_q;
	logic [SPAN_W-1:0]   dvs_q;
	logic [SPAN_W-1:0]   rem_q;
	logic [SPAN_W:0]     shifted;
	logic [SPAN_W-1:0]   rem_next;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		shifted = {rem_q, dvd_q[SEED_W-1]};
		if (shifted >= {1'b0, dvs_q}) begin
			rem_next = SPAN_W'(shifted - {1'b0, dvs_q});
		end else begin
			rem_next = shifted[SPAN_W-1:0];
		end
	end

	// Control and datapath registers of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_STEP;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SEED_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	// The remainder is below the span, which is at most 65536, so 16 bits hold it.
	assign done      = done_q;
	assign remainder = rem_q[BOUND_W-1:0];

endmodule

[src/lcg_random_in_range_core.sv]
// Top level of the bounded random generator: seed update and result delivery.
//
// Usage: each request on the req channel (req_valid, req_stall, low_bound,
// high_bound) asks for one pseudorandom value between the two signed bounds,
// inclusive; the bounds may come in either order. Exactly one response
// follows on the rsp channel (rsp_valid, rsp_stall, random_value), in order.
// The accepting edge starts a bit-serial shift-and-add multiply that advances
// the 31-bit seed; a launch state then starts the remainder unit, which runs
// its one-bit-per-cycle restoring steps, and the result is handed over and
// registered at the output, where rsp_valid rises.
// One request is in flight at a time, so a new request is taken only once
// the last one has finished; req_stall is high from the accepting edge until the
// result has moved into the output register.
// The output register holds a finished response while rsp_stall is high,
// and the next request is taken meanwhile; its computation then waits at the
// end until the held response has gone.
// Reset sets the seed to 81800, empties the output register and leaves the
// block ready for a request.
module lcg_random_in_range_core
	import lcgr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic signed [BOUND_W-1:0]  low_bound,
	input  logic signed [BOUND_W-1:0]  high_bound,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic signed [BOUND_W-1:0]  random_value
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_START,
		S_REM,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [SEED_W-1:0]   seed_q;
	logic [SEED_W-1:0]   mplier_q;
	logic [SEED_W-1:0]   mcand_q;
	logic [SEED_W-1:0]   acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BOUND_W-1:0]  lo_q;
	logic [SPAN_W-1:0]   span_q;
	logic [BOUND_W-1:0]  res_q;
	logic                rsp_valid_q;
	logic [BOUND_W-1:0]  random_value_q;

	logic                req_accept;
	logic                out_free;
	logic                swap;
	logic [BOUND_W-1:0]  lo_sel;
	logic [BOUND_W-1:0]  hi_sel;
	logic [SPAN_W-1:0]   span_next;
	logic [SEED_W-1:0]   acc_next;
	logic                rem_start;
	logic                rem_done;
	logic [BOUND_W-1:0]  rem_value;

	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign rem_start  = (state_q == S_START);

	// Order the bounds and form the span, which lies between 1 and 65536.
	always_comb begin
		swap      = low_bound > high_bound;
		lo_sel    = swap ? high_bound : low_bound;
		hi_sel    = swap ? low_bound : high_bound;
		span_next = SPAN_W'({hi_sel[BOUND_W-1], hi_sel} - {lo_sel[BOUND_W-1], lo_sel}
			+ SPAN_W'(1));
	end

	// One partial product a cycle; the sum wraps at 31 bits as the seed does.
	assign acc_next = acc_q + (mplier_q[0] ? mcand_q : '0);

	lcgr_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (seed_q),
		.divisor   (span_q),
		.done      (rem_done),
		.remainder (rem_value)
	);

	// Sequencer with the seed and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= SEED_RESET;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// A new response loads the output register; a taken one empties it.
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						cnt_q   <= LAST_STEP;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						seed_q  <= acc_next;
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_REM;
				end
				S_REM: begin
					if (rem_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the multiply, the bounds and the result.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			mplier_q <= seed_q;
			mcand_q  <= LCG_MULT;
			acc_q    <= LCG_INC;
			lo_q     <= lo_sel;
			span_q   <= span_next;
		end else if (state_q == S_MUL) begin
			mplier_q <= {1'b0, mplier_q[SEED_W-1:1]};
			mcand_q  <= {mcand_q[SEED_W-2:0], 1'b0};
			acc_q    <= acc_next;
		end
		if (state_q == S_REM && rem_done) begin
			res_q <= rem_value + lo_q;
		end
		if (state_q == S_OUT && out_free) begin
			random_value_q <= res_q;
		end
	end

	assign req_stall    = (state_q != S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign random_value = random_value_q;

endmodule

[src/lcgr_checker.sv]
// Port-level checker for the bounded random generator, bound to the top level.
module lcgr_checker
	import lcgr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic signed [BOUND_W-1:0]  low_bound,
	input  logic signed [BOUND_W-1:0]  high_bound,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  logic signed [BOUND_W-1:0]  random_value
);

	logic                       req_fire;
	logic                       rsp_fire;
	logic [1:0]                 pend_q;
	logic signed [BOUND_W-1:0]  min_q;
	logic signed [BOUND_W-1:0]  max_q;

	assign req_fire = req_valid && !req_stall;
	assign rsp_fire = rsp_valid && !rsp_stall;

	// Requests taken but not yet answered, and the bounds of the latest one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, req_fire} - {1'b0, rsp_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			min_q <= (low_bound > high_bound) ? high_bound : low_bound;
			max_q <= (low_bound > high_bound) ? low_bound : high_bound;
		end
	end

	// A held response keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(random_value))
		else $error("response changed while stalled");

	// No response appears without a request behind it.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an outstanding request");

	// At most one request is in flight besides a waiting response.
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> pend_q == 2'd0 || pend_q == 2'd1)
		else $error("request taken while another is in flight");

	// The answer to the only outstanding request lies between its bounds.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && pend_q == 2'd1 |-> random_value >= min_q && random_value <= max_q)
		else $error("response outside the requested bounds");

endmodule

bind lcg_random_in_range_core lcgr_checker u_lcgr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.low_bound    (low_bound),
	.high_bound   (high_bound),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.random_value (random_value)
);

[tb/sv/tb_lcg_random_in_range_core.sv]
// Self-checking testbench for the bounded linear congruential random generator.
module tb_lcg_random_in_range_core;
	import lcgr_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_REQUESTS = 1530;

	// Generator constants, kept separately from the design's package.
	localparam logic [30:0] SEED_START = 31'd81800;
	localparam longint unsigned LCG_MULTIPLIER = 64'd1103515245;
	localparam longint unsigned LCG_INCREMENT = 64'd81800;

	typedef struct {
		logic signed [BOUND_W-1:0] lo;
		logic signed [BOUND_W-1:0] hi;
	} bounds_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic signed [BOUND_W-1:0] low_bound = '0;
	logic signed [BOUND_W-1:0] high_bound = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [BOUND_W-1:0] random_value;

	bounds_t pending_requests[$];
	logic signed [BOUND_W-1:0] expected_values[$];
	logic [30:0] lcg_seed;
	int total_requests;
	int n_issued;
	int n_accepted;
	int n_checked;
	int fail_count;
	int cycle_count;

	lcg_random_in_range_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.random_value (random_value)
	);

	always #5 clk = ~clk;

	// Advances the seed once and returns the value it picks between the two bounds.
	function automatic logic signed [BOUND_W-1:0] draw_in_range(
		input logic signed [BOUND_W-1:0] a,
		input logic signed [BOUND_W-1:0] b
	);
		int lo;
		int hi;
		longint unsigned product;
		longint seed_now;
		longint span;
		longint pick;
		lo = a;
		hi = b;
		if (lo > hi) begin
			lo = b;
			hi = a;
		end
		product = LCG_MULTIPLIER * 64'(lcg_seed) + LCG_INCREMENT;
		lcg_seed = product[30:0];
		seed_now = lcg_seed;
		span = hi - lo + 1;
		pick = seed_now % span + lo;
		return pick[BOUND_W-1:0];
	endfunction

	task automatic add_request(input int a, input int b);
		bounds_t req;
		req.lo = BOUND_W'(a);
		req.hi = BOUND_W'(b);
		pending_requests.push_back(req);
	endtask

	// The sender idles rarely at first, then often, then never.
	function automatic int sender_idle_pct(input int issued);
		if (issued < total_requests / 3)
			return 10;
		else if (issued < 2 * total_requests / 3)
			return 86;
		return 0;
	endfunction

	// The receiver stalls often at first, then rarely, then never.
	function automatic int receiver_stall_pct(input int checked);
		if (checked < total_requests / 3)
			return 86;
		else if (checked < 2 * total_requests / 3)
			return 10;
		return 0;
	endfunction

	// Request driver: predicts each accepted request and presents the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			low_bound <= '0;
			high_bound <= '0;
			n_accepted <= 0;
			n_issued = 0;
			lcg_seed = SEED_START;
		end else begin : drive_blk
			bit accepted;
			bit hold_off;
			int accepted_now;
			bounds_t req;
			accepted = req_valid && !req_stall;
			accepted_now = n_accepted;
			if (accepted) begin
				expected_values.push_back(draw_in_range(low_bound, high_bound));
				accepted_now = n_accepted + 1;
				n_accepted <= accepted_now;
			end
			// A stalled request stays on the bus unchanged.
			if (!(req_valid && !accepted)) begin
				// At each change of phase, wait until every result is back.
				hold_off = (n_issued == total_requests / 3 || n_issued == 2 * total_requests / 3)
					&& n_checked != accepted_now;
				if (pending_requests.size() != 0 && !hold_off
						&& $urandom_range(0, 99) >= sender_idle_pct(n_issued)) begin
					req = pending_requests.pop_front();
					n_issued++;
					req_valid <= 1'b1;
					low_bound <= req.lo;
					high_bound <= req.hi;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			n_checked <= 0;
		end else begin : check_blk
			logic signed [BOUND_W-1:0] wanted;
			if (rsp_valid && !rsp_stall) begin
				if (expected_values.size() == 0) begin
					$error("random_value: expected none, actual %0d", random_value);
					fail_count++;
				end else begin
					wanted = expected_values.pop_front();
					if (random_value !== wanted) begin
						$error("random_value: expected %0d, actual %0d", wanted, random_value);
						fail_count++;
					end
				end
				n_checked <= n_checked + 1;
			end
			rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct(n_checked));
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL lcg_random_in_range_core");
			$finish;
		end
	end

	initial begin
		int a;
		int b;
		int kind;
		fail_count = 0;
		cycle_count = 0;

		// Directed requests: extreme bounds, reversed order, equal bounds, full range.
		add_request(-32768, 32767);
		add_request(32767, -32768);
		add_request(0, 0);
		add_request(-32768, -32768);
		add_request(32767, 32767);
		add_request(-1, -1);
		add_request(5, -5);
		add_request(-5, 5);
		add_request(0, 1);
		add_request(1, 0);
		add_request(-1, 0);
		add_request(100, 200);
		add_request(-32768, -32767);
		add_request(32767, 32766);
		add_request(0, 32767);
		add_request(-32768, 0);
		add_request(21845, -21846);
		add_request(-21846, 21845);
		add_request(-32768, 32767);
		add_request(1000, 1000);

		// Random requests, weighted towards narrow and degenerate ranges.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			a = int'($urandom_range(0, 65535)) - 32768;
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					b = int'($urandom_range(0, 65535)) - 32768;
				end
				4, 5: begin
					b = a + int'($urandom_range(0, 15));
					if (b > 32767)
						b = 32767;
				end
				6: begin
					b = a;
				end
				7: begin
					a = -32768;
					b = 32767;
				end
				default: begin
					b = a + int'($urandom_range(0, 1023));
					if (b > 32767)
						b = 32767;
				end
			endcase
			if ($urandom_range(0, 1))
				add_request(a, b);
			else
				add_request(b, a);
		end
		total_requests = pending_requests.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request has gone in and every result has come back.
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || req_valid || n_checked != n_accepted);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_values.size() != 0) begin
			$error("random_value: %0d results never arrived", expected_values.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS lcg_random_in_range_core");
		else
			$display("FAIL lcg_random_in_range_core");
		$finish;
	end

endmodule
